// ----- hdl/pfde_pkg.sv -----
// ----------------------------------------------------------------------------
// Page framebuffer draw engine package
// Shared constants, command codes and transaction types for the draw engine.
// ----------------------------------------------------------------------------
package pfde_pkg;

    localparam int COLUMNS = 128;
    localparam int PAGES   = 8;
    localparam int ROWS    = PAGES * 8;
    localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int PG_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int GLYPH_COLS = 5;

    localparam logic [2:0] MODE_CLEAR  = 3'd0;
    localparam logic [2:0] MODE_PIXEL  = 3'd1;
    localparam logic [2:0] MODE_HLINE  = 3'd2;
    localparam logic [2:0] MODE_VLINE  = 3'd3;
    localparam logic [2:0] MODE_BOX    = 3'd4;
    localparam logic [2:0] MODE_GLYPH  = 3'd5;
    localparam logic [2:0] MODE_DGLYPH = 3'd6;
    localparam logic [2:0] MODE_READ   = 3'd7;

    typedef struct packed {
        logic [2:0] mode;
        logic [6:0] x_first;
        logic [5:0] y_first;
        logic [6:0] x_second;
        logic [5:0] y_second;
        logic       pixel_value;
        logic [7:0] glyph_col0;
        logic [7:0] glyph_col1;
        logic [7:0] glyph_col2;
        logic [7:0] glyph_col3;
        logic [7:0] glyph_col4;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
    } rsp_t;

    typedef struct packed {
        logic [2:0]      mode;
        logic [6:0]      x1;
        logic [6:0]      x2;
        logic [6:0]      xlo;
        logic [6:0]      xhi;
        logic [5:0]      y1;
        logic [5:0]      y2;
        logic [5:0]      ylo;
        logic [5:0]      yhi;
        logic            pv;
        logic [9:0]      dbase;
        logic [4:0][7:0] glyph;
    } draw_t;

    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_col;
        logic             wr_en;
        logic [COL_W-1:0] wr_col;
        logic             zero;
    } lane_ctl_t;

    function automatic logic [7:0] double_nibble(input logic [3:0] n);
        logic [7:0] r;
        r = 8'h00;
        if (n[0]) r = r | 8'h03;
        if (n[1]) r = r | 8'h0c;
        if (n[2]) r = r | 8'h30;
        if (n[3]) r = r | 8'hc0;
        return r;
    endfunction

endpackage

// ----- hdl/pfde_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/pfde_lane.sv -----
// ----------------------------------------------------------------------------
// Draw engine page lane
// Holds one page of column bytes and applies the drawing command to each
// column byte as the sweep passes it.
// ----------------------------------------------------------------------------
module pfde_lane
    import pfde_pkg::*;
(
    input  logic            clk,
    input  logic [PG_W-1:0] page,
    input  lane_ctl_t       ctl,
    input  draw_t           draw,
    output logic [7:0]      rdata
);

    logic [7:0] wdata;

    function automatic logic [7:0] hbit(input int y, input int p);
        logic [7:0] r;
        r = 8'h00;
        if ((y >> 3) == p)
        begin
            r[y & 7] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [7:0] rowmask(input int lo, input int hi, input int p);
        logic [7:0] r;
        int row;
        for (int n = 0; n < 8; n++)
        begin
            row = p * 8 + n;
            r[n] = (row >= lo) && (row <= hi);
        end
        return r;
    endfunction

    always_comb
    begin
        int c;
        int p;
        int i;
        int s;
        logic [7:0]  b;
        logic [7:0]  g;
        logic [15:0] bits;
        logic [15:0] msk;
        logic        in_x;
        c    = int'(ctl.wr_col);
        p    = int'(page);
        b    = rdata;
        wdata = b;
        in_x = (c >= int'(draw.xlo)) && (c <= int'(draw.xhi));
        i    = 0;
        s    = int'(draw.y1[2:0]);
        g    = 8'h00;
        bits = 16'h0000;
        msk  = 16'h0000;
        case (draw.mode)
            MODE_CLEAR:
            begin
                wdata = 8'h00;
            end
            MODE_PIXEL:
            begin
                if (c == int'(draw.x1) && draw.pv)
                begin
                    wdata = b | hbit(int'(draw.y1), p);
                end
            end
            MODE_HLINE:
            begin
                if (in_x)
                begin
                    wdata = b | hbit(int'(draw.y1), p);
                end
            end
            MODE_VLINE:
            begin
                if (c == int'(draw.x1))
                begin
                    wdata = b | rowmask(int'(draw.ylo), int'(draw.yhi), p);
                end
            end
            MODE_BOX:
            begin
                if (in_x)
                begin
                    wdata = wdata | hbit(int'(draw.y1), p) | hbit(int'(draw.y2), p);
                end
                if (c == int'(draw.x1) || c == int'(draw.x2))
                begin
                    wdata = wdata | rowmask(int'(draw.ylo), int'(draw.yhi), p);
                end
            end
            MODE_GLYPH:
            begin
                if (c >= int'(draw.x1) && c < int'(draw.x1) + GLYPH_COLS)
                begin
                    i    = c - int'(draw.x1);
                    g    = draw.glyph[i[2:0]];
                    bits = {8'h00, g} << s;
                    msk  = 16'h00ff << s;
                    if (p == int'(draw.y1[5:3]))
                    begin
                        wdata = (b & ~msk[7:0]) | bits[7:0];
                    end
                    else if (p == int'(draw.y1[5:3]) + 1)
                    begin
                        wdata = (b & ~msk[15:8]) | bits[15:8];
                    end
                end
            end
            MODE_DGLYPH:
            begin
                if (c >= int'(draw.dbase) && c < int'(draw.dbase) + 2 * GLYPH_COLS)
                begin
                    i = (c - int'(draw.dbase)) >> 1;
                    g = draw.glyph[i[2:0]];
                    if (p == int'(draw.y1))
                    begin
                        wdata = double_nibble(g[3:0]);
                    end
                    else if (p == int'(draw.y1) + 1)
                    begin
                        wdata = double_nibble(g[7:4]);
                    end
                end
            end
            default:
            begin
                wdata = b;
            end
        endcase
        if (ctl.zero)
        begin
            wdata = 8'h00;
        end
    end

    pfde_ram #(
        .WIDTH (8),
        .DEPTH (COLUMNS)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.wr_en),
        .waddr (ctl.wr_col),
        .wdata (wdata),
        .re    (ctl.rd_en),
        .raddr (ctl.rd_col),
        .rdata (rdata)
    );

endmodule

// ----- hdl/pfde_merge.sv -----
// ----------------------------------------------------------------------------
// Draw engine result merge
// Selects the read byte from the addressed page lane and registers the
// result transaction with its strobe.
// ----------------------------------------------------------------------------
module pfde_merge
    import pfde_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       lane_data [PAGES],
    input  logic [PG_W-1:0]  page_sel,
    input  logic             fin,
    input  logic             is_read,
    input  logic             err,
    output logic             done,
    output rsp_t             result
);

    logic done_reg;
    logic done_next;
    rsp_t result_reg;
    rsp_t result_next;

    always_comb
    begin
        done_next = fin;
        result_next.status = err;
        result_next.read_data = (is_read && !err) ? lane_data[page_sel] : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- hdl/page_framebuffer_draw_engine.sv -----
// ----------------------------------------------------------------------------
// Page framebuffer draw engine
// Out-of-range commands report in the cycle after acceptance. Reads pass
// through ST_READ and ST_RWAIT; drawing and clear commands pass through
// ST_SWEEP, one read-modify-write sweep over the columns in all page lanes
// at once, then ST_DRAIN. Reset zeroes every column with busy held high.
// Results cannot be stalled; a new command is taken once busy is low.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine
    import pfde_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t command,
    output logic done,
    output rsp_t result
);

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_RWAIT = 3'd5;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             wr_en_reg;
    logic             wr_en_next;
    logic [COL_W-1:0] wr_col_reg;
    logic             zero_reg;
    logic             zero_next;
    draw_t            draw_reg;
    draw_t            draw_next;
    lane_ctl_t        ctl;
    logic             accept;
    logic             err;
    logic             fin;
    logic             is_read;
    logic             last_col;
    logic [7:0]       lane_data [PAGES];

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign last_col = (col_reg == COL_W'(COLUMNS - 1));

    always_comb
    begin
        int x1;
        int x2;
        int y1;
        int y2;
        x1 = int'(command.x_first);
        x2 = int'(command.x_second);
        y1 = int'(command.y_first);
        y2 = int'(command.y_second);
        case (command.mode)
            MODE_CLEAR:  err = 1'b0;
            MODE_PIXEL:  err = (x1 >= COLUMNS) || (y1 >= ROWS);
            MODE_HLINE:  err = (x1 >= COLUMNS) || (x2 >= COLUMNS) || (y1 >= ROWS);
            MODE_VLINE:  err = (x1 >= COLUMNS) || (y1 >= ROWS) || (y2 >= ROWS);
            MODE_BOX:    err = (x1 >= COLUMNS) || (x2 >= COLUMNS) || (y1 >= ROWS)
                               || (y2 >= ROWS);
            MODE_GLYPH:  err = (x1 > COLUMNS - 5) || (y1 > ROWS - 7);
            MODE_DGLYPH: err = (x1 + 1 >= COLUMNS / 6) || (y1 + 1 >= PAGES);
            MODE_READ:   err = (x1 >= COLUMNS) || (y1 >= PAGES);
            default:     err = 1'b1;
        endcase
    end

    always_comb
    begin
        draw_next.mode  = command.mode;
        draw_next.x1    = command.x_first;
        draw_next.x2    = command.x_second;
        draw_next.y1    = command.y_first;
        draw_next.y2    = command.y_second;
        draw_next.pv    = command.pixel_value;
        draw_next.xlo   = (command.x_first < command.x_second) ? command.x_first
                                                                : command.x_second;
        draw_next.xhi   = (command.x_first < command.x_second) ? command.x_second
                                                                : command.x_first;
        draw_next.ylo   = (command.y_first < command.y_second) ? command.y_first
                                                                : command.y_second;
        draw_next.yhi   = (command.y_first < command.y_second) ? command.y_second
                                                                : command.y_first;
        draw_next.dbase = {1'b0, command.x_first, 2'b00} + {2'b00, command.x_first, 1'b0};
        draw_next.glyph = {command.glyph_col4, command.glyph_col3, command.glyph_col2,
                           command.glyph_col1, command.glyph_col0};
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        wr_en_next = 1'b0;
        zero_next  = 1'b0;
        fin        = 1'b0;
        is_read    = 1'b0;
        ctl.rd_en  = 1'b0;
        ctl.rd_col = col_reg;
        case (state_reg)
            ST_CLR:
            begin
                wr_en_next = 1'b1;
                zero_next  = 1'b1;
                col_next   = col_reg + 1'b1;
                if (last_col)
                begin
                    col_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    col_next = '0;
                    if (err)
                    begin
                        fin = 1'b1;
                    end
                    else if (command.mode == MODE_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP:
            begin
                ctl.rd_en  = 1'b1;
                wr_en_next = 1'b1;
                col_next   = col_reg + 1'b1;
                if (last_col)
                begin
                    col_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                fin        = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_col = COL_W'(draw_reg.x1);
                state_next = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                fin        = 1'b1;
                is_read    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ctl.wr_en  = wr_en_reg;
        ctl.wr_col = wr_col_reg;
        ctl.zero   = zero_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            col_reg   <= '0;
            wr_en_reg <= 1'b0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            wr_en_reg <= wr_en_next;
            zero_reg  <= zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_col_reg <= col_reg;
        if (accept)
        begin
            draw_reg <= draw_next;
        end
    end

    for (genvar g = 0; g < PAGES; g++)
    begin : g_lane
        pfde_lane u_lane (
            .clk   (clk),
            .page  (PG_W'(g)),
            .ctl   (ctl),
            .draw  (draw_reg),
            .rdata (lane_data[g])
        );
    end

    pfde_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_data (lane_data),
        .page_sel  (PG_W'(draw_reg.y1)),
        .fin       (fin),
        .is_read   (is_read),
        .err       (err && accept),
        .done      (done),
        .result    (result)
    );

endmodule

// ----- hdl/pfde_checker.sv -----
// ----------------------------------------------------------------------------
// Draw engine port checker
// Watches the top-level ports for command and result ordering and result content rules.
// ----------------------------------------------------------------------------
module pfde_checker
    import pfde_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t result
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("Result strobe while busy.");

    a_accept_reacts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("Accepted transaction neither started nor completed.");

    a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |-> (result.read_data == 8'h00))
        else $error("Error result carries read data.");

    a_work_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(busy)) |-> !result.status)
        else $error("Completed work reports an error.");

endmodule

bind page_framebuffer_draw_engine pfde_checker u_pfde_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ----- verif/page_framebuffer_draw_engine_tb.sv -----
// ----------------------------------------------------------------------------
// Page framebuffer draw engine testbench
// Drives draw commands through the start/busy handshake, keeps a shadow copy
// of the frame store, and compares every result against the predicted one.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine_tb;
    import pfde_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 850;
    localparam int CMD_W          = $bits(cmd_t);

    typedef struct {
        cmd_t cmd;
        logic has_result;
        rsp_t result;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t command;
    logic done;
    rsp_t result;

    logic [7:0] shadow_frame [PAGES*COLUMNS];
    rsp_t       expected_results [$];
    int         mismatch_count;
    int         idle_cycles;
    stim_row_t  directed_rows [$];

    page_framebuffer_draw_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic void or_pixel(input int x, input int y);
        shadow_frame[(y / 8) * COLUMNS + x] |= 8'(1 << (y % 8));
    endfunction

    function automatic void or_hline(input int xa, input int xb, input int y);
        int lo;
        int hi;
        lo = (xa < xb) ? xa : xb;
        hi = (xa < xb) ? xb : xa;
        for (int x = lo; x <= hi; x++)
            or_pixel(x, y);
    endfunction

    function automatic void or_vline(input int x, input int ya, input int yb);
        int lo;
        int hi;
        lo = (ya < yb) ? ya : yb;
        hi = (ya < yb) ? yb : ya;
        for (int y = lo; y <= hi; y++)
            or_pixel(x, y);
    endfunction

    function automatic logic [7:0] spread_nibble(input logic [3:0] n);
        logic [7:0] r;
        r = 8'h00;
        for (int b = 0; b < 4; b++)
            if (n[b])
                r[2*b +: 2] = 2'b11;
        return r;
    endfunction

    function automatic rsp_t draw_and_predict(input cmd_t c);
        rsp_t r;
        int x1;
        int y1;
        int x2;
        int y2;
        int p;
        int s;
        int idx;
        logic [15:0] mask;
        logic [15:0] bits;
        logic [7:0] g [5];
        logic [7:0] lo;
        logic [7:0] hi;
        r = '0;
        x1 = c.x_first;
        y1 = c.y_first;
        x2 = c.x_second;
        y2 = c.y_second;
        g[0] = c.glyph_col0;
        g[1] = c.glyph_col1;
        g[2] = c.glyph_col2;
        g[3] = c.glyph_col3;
        g[4] = c.glyph_col4;
        case (c.mode)
            MODE_CLEAR:
                for (int i = 0; i < PAGES*COLUMNS; i++)
                    shadow_frame[i] = 8'h00;
            MODE_PIXEL:
                if (x1 >= COLUMNS || y1 >= ROWS)
                    r.status = 1'b1;
                else if (c.pixel_value)
                    or_pixel(x1, y1);
            MODE_HLINE:
                if (x1 >= COLUMNS || x2 >= COLUMNS || y1 >= ROWS)
                    r.status = 1'b1;
                else
                    or_hline(x1, x2, y1);
            MODE_VLINE:
                if (x1 >= COLUMNS || y1 >= ROWS || y2 >= ROWS)
                    r.status = 1'b1;
                else
                    or_vline(x1, y1, y2);
            MODE_BOX:
                if (x1 >= COLUMNS || x2 >= COLUMNS || y1 >= ROWS || y2 >= ROWS)
                    r.status = 1'b1;
                else
                begin
                    or_hline(x1, x2, y1);
                    or_hline(x1, x2, y2);
                    or_vline(x1, y1, y2);
                    or_vline(x2, y1, y2);
                end
            MODE_GLYPH:
                if (x1 > COLUMNS - 5 || y1 > ROWS - 7)
                    r.status = 1'b1;
                else
                begin
                    p = y1 / 8;
                    s = y1 % 8;
                    mask = 16'h00ff << s;
                    for (int i = 0; i < 5; i++)
                    begin
                        bits = {8'h00, g[i]} << s;
                        idx = p * COLUMNS + x1 + i;
                        shadow_frame[idx] = (shadow_frame[idx] & ~mask[7:0]) | bits[7:0];
                        if (p + 1 < PAGES)
                        begin
                            idx += COLUMNS;
                            shadow_frame[idx] = (shadow_frame[idx] & ~mask[15:8])
                                                | bits[15:8];
                        end
                    end
                end
            MODE_DGLYPH:
                if (x1 + 1 >= COLUMNS / 6 || y1 + 1 >= PAGES)
                    r.status = 1'b1;
                else
                    for (int i = 0; i < 5; i++)
                    begin
                        lo = spread_nibble(g[i][3:0]);
                        hi = spread_nibble(g[i][7:4]);
                        idx = y1 * COLUMNS + x1 * 6 + 2 * i;
                        shadow_frame[idx] = lo;
                        shadow_frame[idx + 1] = lo;
                        shadow_frame[idx + COLUMNS] = hi;
                        shadow_frame[idx + 1 + COLUMNS] = hi;
                    end
            default:
                if (x1 >= COLUMNS || y1 >= PAGES)
                    r.status = 1'b1;
                else
                    r.read_data = shadow_frame[y1 * COLUMNS + x1];
        endcase
        return r;
    endfunction

    function automatic cmd_t make_cmd(input logic [2:0] m, input int x1, input int y1,
                                      input int x2, input int y2, input logic pv,
                                      input logic [39:0] glyph);
        cmd_t c;
        c.mode = m;
        c.x_first = 7'(x1);
        c.y_first = 6'(y1);
        c.x_second = 7'(x2);
        c.y_second = 6'(y2);
        c.pixel_value = pv;
        {c.glyph_col4, c.glyph_col3, c.glyph_col2, c.glyph_col1, c.glyph_col0} = glyph;
        return c;
    endfunction

    function automatic int pick_small_or_any(input int maxv);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, maxv) : $urandom_range(0, 15);
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int sel;
        c = cmd_t'(CMD_W'({$urandom, $urandom, $urandom}));
        sel = $urandom_range(0, 99);
        if (sel < 2)
            c.mode = MODE_CLEAR;
        else if (sel < 90)
            c.mode = 3'($urandom_range(1, 7));
        else
            c.mode = 3'($urandom_range(0, 7));
        if (c.mode == MODE_READ && $urandom_range(0, 4) != 0)
            c.y_first = 6'($urandom_range(0, PAGES - 1));
        if (c.mode == MODE_DGLYPH && $urandom_range(0, 4) != 0)
        begin
            c.x_first = 7'($urandom_range(0, COLUMNS / 6 - 2));
            c.y_first = 6'($urandom_range(0, PAGES - 2));
        end
        if (c.mode == MODE_GLYPH && $urandom_range(0, 4) != 0)
            c.x_first = 7'($urandom_range(0, COLUMNS - 5));
        if ((c.mode == MODE_HLINE || c.mode == MODE_BOX) && $urandom_range(0, 1) == 0)
            c.x_second = 7'(c.x_first + pick_small_or_any(127));
        if ((c.mode == MODE_VLINE || c.mode == MODE_BOX) && $urandom_range(0, 1) == 0)
            c.y_second = 6'(c.y_first + pick_small_or_any(63));
        return c;
    endfunction

    task automatic wait_random_gap();
        int gap;
        if ($urandom_range(0, 2) == 0)
            gap = 0;
        else if ($urandom_range(0, 15) == 0)
            gap = $urandom_range(20, 200);
        else
            gap = $urandom_range(1, 4);
        if (gap != 0)
            start <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    task automatic issue_command(input cmd_t c);
        start <= 1'b1;
        command <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(draw_and_predict(c));
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result: read_data=%0h status=%0b",
                             result.read_data, result.status);
            end
            else
            begin
                rsp_t exp_r;
                exp_r = expected_results.pop_front();
                if (result.read_data !== exp_r.read_data || result.status !== exp_r.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Result mismatch: expected read_data=%0h status=%0b, got read_data=%0h status=%0b",
                                 exp_r.read_data, exp_r.status, result.read_data,
                                 result.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        stim_row_t row;
        cmd_t c;
        rsp_t exp_r;
        rst_n = 1'b0;
        start = 1'b0;
        command = '0;
        mismatch_count = 0;
        for (int i = 0; i < PAGES*COLUMNS; i++)
            shadow_frame[i] = 8'h00;

        directed_rows = '{
            '{make_cmd(MODE_READ, 0, 0, 0, 0, 0, '0), 1'b1, rsp_t'{8'h00, 1'b0}},
            '{make_cmd(MODE_READ, 127, 7, 0, 0, 0, '0), 1'b1, rsp_t'{8'h00, 1'b0}},
            '{make_cmd(MODE_READ, 127, 8, 0, 0, 0, '0), 1'b1, rsp_t'{8'h00, 1'b1}},
            '{make_cmd(MODE_PIXEL, 0, 0, 0, 0, 1, '0), 1'b1, rsp_t'{8'h00, 1'b0}},
            '{make_cmd(MODE_READ, 0, 0, 0, 0, 0, '0), 1'b1, rsp_t'{8'h01, 1'b0}},
            '{make_cmd(MODE_PIXEL, 127, 63, 0, 0, 1, '0), 1'b1, rsp_t'{8'h00, 1'b0}},
            '{make_cmd(MODE_READ, 127, 7, 0, 0, 0, '0), 1'b1, rsp_t'{8'h80, 1'b0}},
            '{make_cmd(MODE_PIXEL, 5, 9, 0, 0, 0, '0), 1'b0, rsp_t'{8'h00, 1'b0}},
            '{make_cmd(MODE_HLINE, 127, 10, 0, 63, 0, '0), 1'b0, rsp_t'{8'h00, 1'b0}},
            '{make_cmd(MODE_VLINE, 3, 63, 0, 0, 0, '0), 1'b0, rsp_t'{8'h00, 1'b0}},
            '{make_cmd(MODE_BOX, 0, 0, 127, 63, 0, '0), 1'b0, rsp_t'{8'h00, 1'b0}},
            '{make_cmd(MODE_BOX, 20, 30, 20, 30, 0, '0), 1'b0, rsp_t'{8'h00, 1'b0}},
            '{make_cmd(MODE_GLYPH, 123, 57, 0, 0, 0, 40'hff_a5_5a_00_ff),
              1'b0, rsp_t'{8'h00, 1'b0}},
            '{make_cmd(MODE_GLYPH, 124, 0, 0, 0, 0, '1), 1'b1, rsp_t'{8'h00, 1'b1}},
            '{make_cmd(MODE_GLYPH, 0, 58, 0, 0, 0, '1), 1'b1, rsp_t'{8'h00, 1'b1}},
            '{make_cmd(MODE_GLYPH, 40, 13, 0, 0, 0, 40'h81_42_24_18_ff),
              1'b0, rsp_t'{8'h00, 1'b0}},
            '{make_cmd(MODE_DGLYPH, 19, 6, 0, 0, 0, 40'h0f_f0_3c_c3_ff),
              1'b0, rsp_t'{8'h00, 1'b0}},
            '{make_cmd(MODE_DGLYPH, 20, 0, 0, 0, 0, '1), 1'b1, rsp_t'{8'h00, 1'b1}},
            '{make_cmd(MODE_DGLYPH, 0, 7, 0, 0, 0, '1), 1'b1, rsp_t'{8'h00, 1'b1}},
            '{make_cmd(MODE_READ, 114, 6, 0, 0, 0, '0), 1'b1, rsp_t'{8'hff, 1'b0}},
            '{make_cmd(MODE_READ, 64, 3, 0, 0, 0, '0), 1'b0, rsp_t'{8'h00, 1'b0}},
            '{make_cmd(MODE_PIXEL, 0, 64, 0, 0, 1, '0), 1'b1, rsp_t'{8'h00, 1'b0}},
            '{make_cmd(MODE_VLINE, 0, 0, 0, 63, 0, '0), 1'b0, rsp_t'{8'h00, 1'b0}},
            '{make_cmd(MODE_CLEAR, 0, 0, 0, 0, 0, '0), 1'b1, rsp_t'{8'h00, 1'b0}},
            '{make_cmd(MODE_READ, 0, 0, 0, 0, 0, '0), 1'b1, rsp_t'{8'h00, 1'b0}}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            issue_command(row.cmd);
            if (row.has_result)
            begin
                exp_r = expected_results[$];
                if (exp_r !== row.result)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Table row %0d: predicted %0h, table gives %0h",
                                 i, exp_r, row.result);
                end
            end
            wait_random_gap();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            c = random_cmd();
            issue_command(c);
            if (n % 200 == 100)
                wait_results_drained();
            else if ((n / 100) % 3 != 2)
                wait_random_gap();
        end

        wait_results_drained();
        repeat (COLUMNS + 10) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- page_framebuffer_draw_engine.f -----
hdl/pfde_pkg.sv
hdl/pfde_ram.sv
hdl/pfde_lane.sv
hdl/pfde_merge.sv
hdl/page_framebuffer_draw_engine.sv
hdl/pfde_checker.sv
verif/page_framebuffer_draw_engine_tb.sv
